[hw/rtl/sws_pkg.sv]
// Shared types and constants for the separator word splitter.
`default_nettype none

package sws_pkg;

    localparam int SWS_OFFSET_BITS = 20;
    localparam int SWS_FIELD_BITS  = 20;
    localparam int SWS_MAX_SEP     = 8;
    localparam int SWS_QDEPTH      = 4;
    localparam int SWS_QPTR_BITS   = $clog2(SWS_QDEPTH);

    localparam logic [7:0] SWS_CHAR_NUL = 8'h00;
    localparam logic [7:0] SWS_CHAR_NL  = 8'h0A;

    localparam logic [1:0] CFG_SEP_LEN   = 2'd0;
    localparam logic [1:0] CFG_SEP_BYTES = 2'd1;

    typedef enum logic [1:0] {
        END_TEXT      = 2'd0,
        END_NEWLINE   = 2'd1,
        END_SEPARATOR = 2'd2
    } end_kind_t;

    typedef struct packed {
        logic [SWS_FIELD_BITS-1:0] word_start;
        logic [SWS_FIELD_BITS-1:0] word_length;
        end_kind_t                 end_kind;
        logic                      offset_saturated;
        logic                      last_of_run;
    } sws_result_t;

    typedef struct packed {
        logic        valid0;
        logic        valid1;
        sws_result_t res0;
        sws_result_t res1;
    } sws_push_t;

    typedef struct packed {
        logic [SWS_QPTR_BITS:0] level;
        logic                   space;
    } sws_qstat_t;

endpackage

`default_nettype wire

[hw/rtl/sws_tokenizer.sv]
// Word tokenizer: match state, offset counters and per-byte result generation.
`default_nettype none

module sws_tokenizer
    import sws_pkg::*;
#(
    parameter int OFFSET_BITS = SWS_OFFSET_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  text_byte,
    input  wire logic [3:0]  sep_len,
    input  wire logic [63:0] sep_bytes,
    output sws_push_t        push
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    logic                   in_sep_reg, in_sep_next;
    logic [3:0]             mc_reg, mc_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [OFFSET_BITS-1:0] cws_reg, cws_next;
    logic                   sat_reg, sat_next;

    logic [3:0]             eff_len;
    logic                   full;
    logic [OFFSET_BITS-1:0] mc_ext;
    logic [OFFSET_BITS-1:0] sep_at;
    logic [7:0]             sel_byte;
    logic                   word_chk;
    sws_result_t            nl_res;

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        sat_inc = (v == OFF_MAX) ? v : v + OFFSET_BITS'(1);
    endfunction

    function automatic sws_result_t make_res(
        input logic [OFFSET_BITS-1:0] start,
        input logic [OFFSET_BITS-1:0] stop,
        input end_kind_t              kind,
        input logic                   sat,
        input logic                   last
    );
        sws_result_t            r;
        logic [OFFSET_BITS-1:0] len;
        logic [31:0]            s32;
        logic [31:0]            l32;
        len                = (stop > start) ? stop - start : '0;
        s32                = 32'(start);
        l32                = 32'(len);
        r.word_start       = s32[SWS_FIELD_BITS-1:0];
        r.word_length      = l32[SWS_FIELD_BITS-1:0];
        r.end_kind         = kind;
        r.offset_saturated = sat;
        r.last_of_run      = last;
        make_res           = r;
    endfunction

    always_comb
    begin
        if (sep_len == 4'd0)
        begin
            eff_len = 4'd1;
        end
        else if (sep_len > 4'(SWS_MAX_SEP))
        begin
            eff_len = 4'(SWS_MAX_SEP);
        end
        else
        begin
            eff_len = sep_len;
        end
    end

    assign full     = (mc_reg >= eff_len);
    assign mc_ext   = OFFSET_BITS'(mc_reg);
    assign sep_at   = (off_reg > mc_ext) ? off_reg - mc_ext : '0;
    assign sel_byte = sep_bytes[8*mc_reg[2:0] +: 8];

    always_comb
    begin
        in_sep_next = in_sep_reg;
        mc_next     = mc_reg;
        off_next    = off_reg;
        cws_next    = cws_reg;
        sat_next    = sat_reg;
        push        = '0;
        word_chk    = 1'b0;
        nl_res      = '0;

        if (text_byte == SWS_CHAR_NUL)
        begin
            push.valid0 = 1'b1;
            push.res0   = make_res(cws_reg, off_reg, END_TEXT, sat_reg, 1'b1);
            in_sep_next = 1'b0;
            mc_next     = '0;
            off_next    = '0;
            cws_next    = '0;
            sat_next    = 1'b0;
        end
        else
        begin
            if (!in_sep_reg)
            begin
                word_chk = 1'b1;
            end
            else if (!full && text_byte == sel_byte)
            begin
                mc_next = mc_reg + 4'd1;
            end
            else if (full)
            begin
                push.valid0 = 1'b1;
                push.res0   = make_res(cws_reg, sep_at,
                                       (text_byte == SWS_CHAR_NL) ? END_NEWLINE : END_SEPARATOR,
                                       sat_reg, 1'b1);
                cws_next    = off_reg;
                in_sep_next = 1'b0;
                mc_next     = '0;
                word_chk    = 1'b1;
            end
            else if (text_byte == SWS_CHAR_NL)
            begin
                push.valid0 = 1'b1;
                push.res0   = make_res(cws_reg, off_reg, END_NEWLINE, sat_reg, 1'b1);
                cws_next    = sat_inc(off_reg);
                in_sep_next = 1'b0;
                mc_next     = '0;
            end
            else
            begin
                in_sep_next = 1'b0;
                mc_next     = '0;
            end

            if (word_chk)
            begin
                if (text_byte == sep_bytes[7:0])
                begin
                    in_sep_next = 1'b1;
                    mc_next     = 4'd1;
                end
                else if (text_byte == SWS_CHAR_NL)
                begin
                    nl_res = make_res(cws_next, off_reg, END_NEWLINE, sat_reg, 1'b1);
                    if (push.valid0)
                    begin
                        push.res0.last_of_run = 1'b0;
                        push.valid1           = 1'b1;
                        push.res1             = nl_res;
                    end
                    else
                    begin
                        push.valid0 = 1'b1;
                        push.res0   = nl_res;
                    end
                    cws_next = sat_inc(off_reg);
                end
            end

            off_next = sat_inc(off_reg);
            if (off_next == OFF_MAX)
            begin
                sat_next = 1'b1;
            end
        end

        if (!accept)
        begin
            push.valid0 = 1'b0;
            push.valid1 = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sep_reg <= 1'b0;
            mc_reg     <= '0;
            off_reg    <= '0;
            cws_reg    <= '0;
            sat_reg    <= 1'b0;
        end
        else if (accept)
        begin
            in_sep_reg <= in_sep_next;
            mc_reg     <= mc_next;
            off_reg    <= off_next;
            cws_reg    <= cws_next;
            sat_reg    <= sat_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sws_result_queue.sv]
// Result queue: takes up to two results per cycle, delivers one word per cycle while pop is high.
`default_nettype none

module sws_result_queue
    import sws_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire sws_push_t push,
    input  wire logic  pop,
    output logic       head_valid,
    output sws_result_t head,
    output sws_qstat_t stat
);

    sws_result_t              mem [SWS_QDEPTH];
    logic [SWS_QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [SWS_QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [SWS_QPTR_BITS:0]   count_reg, count_next;
    logic [SWS_QPTR_BITS:0]   push_n;
    logic                     do_pop;

    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;
    assign push_n     = (SWS_QPTR_BITS+1)'(push.valid0) + (SWS_QPTR_BITS+1)'(push.valid1);

    assign wr_ptr_next = wr_ptr_reg + push_n[SWS_QPTR_BITS-1:0];
    assign rd_ptr_next = rd_ptr_reg + SWS_QPTR_BITS'(do_pop);
    assign count_next  = count_reg + push_n - (SWS_QPTR_BITS+1)'(do_pop);

    assign stat.level = count_reg;
    assign stat.space = (count_reg <= (SWS_QPTR_BITS+1)'(SWS_QDEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.valid1)
        begin
            mem[wr_ptr_reg + SWS_QPTR_BITS'(1)] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/separator_word_splitter_top.sv]
// Each accepted byte's results are written into the result queue; out_valid comes from the registered queue count.
// Throughput: one byte per cycle while in_ready is high; a byte that ends a separator on a newline gives
//   two words, which leave the 4-entry result queue in order, one per output handshake.
// in_ready drops while the result queue has fewer than two free entries.
// Reset (async, active low): match state, offsets and queue clear; separator
//   length returns to 1 and separator bytes to a single space.
`default_nettype none

module separator_word_splitter_top
    import sws_pkg::*;
#(
    parameter int OFFSET_BITS = SWS_OFFSET_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [7:0]                text_byte,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [SWS_FIELD_BITS-1:0]      word_start,
    output logic [SWS_FIELD_BITS-1:0]      word_length,
    output logic [1:0]                     end_kind,
    output logic                           offset_saturated,
    output logic                           last_of_run,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [63:0]               cfg_data
);

    logic [3:0]  sep_len_reg;
    logic [63:0] sep_bytes_reg;
    logic        accept;
    sws_push_t   push;
    sws_result_t head;
    sws_qstat_t  qstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_len_reg   <= 4'd1;
            sep_bytes_reg <= 64'd32;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SEP_LEN:   sep_len_reg   <= cfg_data[3:0];
                CFG_SEP_BYTES: sep_bytes_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign in_ready = qstat.space;
    assign accept   = in_valid && in_ready;

    sws_tokenizer #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_tokenizer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text_byte),
        .sep_len   (sep_len_reg),
        .sep_bytes (sep_bytes_reg),
        .push      (push)
    );

    sws_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (out_ready),
        .head_valid (out_valid),
        .head       (head),
        .stat       (qstat)
    );

    assign word_start       = head.word_start;
    assign word_length      = head.word_length;
    assign end_kind         = head.end_kind;
    assign offset_saturated = head.offset_saturated;
    assign last_of_run      = head.last_of_run;

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.level <= (SWS_QPTR_BITS+1)'(SWS_QDEPTH))
        else $error("result queue overflow");

    a_eot_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && text_byte == SWS_CHAR_NUL) |=> out_valid)
        else $error("end of text gave no word");

    a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_kind == END_TEXT) |-> last_of_run)
        else $error("end-of-text word not last of run");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid1 |-> (push.valid0 && !push.res0.last_of_run && push.res1.last_of_run))
        else $error("bad two-word ordering");
`endif

endmodule

`default_nettype wire

[tb/sv/separator_word_splitter_top_tb.sv]
// Self-checking testbench for separator_word_splitter_top: directed and random text.
`timescale 1ns / 1ps

module separator_word_splitter_top_tb;
    import sws_pkg::*;

    localparam logic [SWS_FIELD_BITS-1:0] OFS_TOP = {SWS_OFFSET_BITS{1'b1}};
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_PRINTS     = 50;

    logic                      clk;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    logic [7:0]                text_byte  = 8'h00;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic [SWS_FIELD_BITS-1:0] word_start;
    logic [SWS_FIELD_BITS-1:0] word_length;
    logic [1:0]                end_kind;
    logic                      offset_saturated;
    logic                      last_of_run;
    logic                      cfg_valid  = 1'b0;
    logic                      cfg_ready;
    logic [1:0]                cfg_index  = CFG_SEP_LEN;
    logic [63:0]               cfg_data   = 64'h0;

    // predictor state and register copies
    logic [3:0]                sep_len_reg;
    logic [63:0]               sep_bytes_reg;
    logic                      in_sep;
    logic [3:0]                match_cnt;
    logic [SWS_FIELD_BITS-1:0] text_ofs;
    logic [SWS_FIELD_BITS-1:0] word_begin;
    logic                      ofs_full;

    sws_result_t words_due[$];
    sws_result_t step_words[$];

    int err_cnt       = 0;
    int bytes_in      = 0;
    int words_seen    = 0;
    int reg_writes    = 0;
    int idle_cnt      = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    separator_word_splitter_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .text_byte        (text_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .word_start       (word_start),
        .word_length      (word_length),
        .end_kind         (end_kind),
        .offset_saturated (offset_saturated),
        .last_of_run      (last_of_run),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int sep_width();
        int n;
        n = sep_len_reg;
        if (n == 0)
            n = 1;
        if (n > SWS_MAX_SEP)
            n = SWS_MAX_SEP;
        return n;
    endfunction

    function automatic logic [7:0] sep_char(input int i);
        return sep_bytes_reg[(i % 8) * 8 +: 8];
    endfunction

    function automatic logic [SWS_FIELD_BITS-1:0] bump(input logic [SWS_FIELD_BITS-1:0] v);
        return (v == OFS_TOP) ? v : v + SWS_FIELD_BITS'(1);
    endfunction

    function automatic logic [7:0] word_char();
        if ($urandom_range(4) == 0)
            return 8'($urandom_range(1, 255));
        return 8'($urandom_range(97, 122));
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (err_cnt < MAX_PRINTS)
            $display("mismatch in %s at word %0d: got %0d, expected %0d",
                     what, words_seen, got, want);
        err_cnt++;
    endtask

    task automatic note_word(input logic [SWS_FIELD_BITS-1:0] first_ofs,
                             input logic [SWS_FIELD_BITS-1:0] stop_ofs,
                             input end_kind_t kind);
        sws_result_t w;
        w.word_start       = first_ofs;
        w.word_length      = (stop_ofs > first_ofs) ? stop_ofs - first_ofs : '0;
        w.end_kind         = kind;
        w.offset_saturated = ofs_full;
        w.last_of_run      = 1'b0;
        step_words         = {step_words, w};
    endtask

    task automatic body_byte(input logic [7:0] b, input logic [SWS_FIELD_BITS-1:0] p);
        if (b == sep_char(0))
        begin
            in_sep    = 1'b1;
            match_cnt = 4'd1;
        end
        else if (b == SWS_CHAR_NL)
        begin
            note_word(word_begin, p, END_NEWLINE);
            word_begin = bump(p);
        end
    endtask

    task automatic predict_words(input logic [7:0] b);
        logic [SWS_FIELD_BITS-1:0] p;
        logic [SWS_FIELD_BITS-1:0] sep_at;
        logic                      full;
        step_words.delete();
        p = text_ofs;
        if (b == SWS_CHAR_NUL)
        begin
            note_word(word_begin, p, END_TEXT);
            in_sep     = 1'b0;
            match_cnt  = '0;
            text_ofs   = '0;
            word_begin = '0;
            ofs_full   = 1'b0;
        end
        else
        begin
            if (!in_sep)
                body_byte(b, p);
            else
            begin
                full   = (match_cnt >= sep_width());
                sep_at = (p > match_cnt) ? p - match_cnt : '0;
                if (!full && b == sep_char(match_cnt))
                    match_cnt = match_cnt + 4'd1;
                else if (full)
                begin
                    if (b == SWS_CHAR_NL)
                        note_word(word_begin, sep_at, END_NEWLINE);
                    else
                        note_word(word_begin, sep_at, END_SEPARATOR);
                    word_begin = p;
                    in_sep     = 1'b0;
                    match_cnt  = '0;
                    body_byte(b, p);
                end
                else if (b == SWS_CHAR_NL)
                begin
                    note_word(word_begin, p, END_NEWLINE);
                    word_begin = bump(p);
                    in_sep     = 1'b0;
                    match_cnt  = '0;
                end
                else
                begin
                    in_sep    = 1'b0;
                    match_cnt = '0;
                end
            end
            text_ofs = bump(p);
            if (text_ofs == OFS_TOP)
                ofs_full = 1'b1;
        end
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last_of_run = 1'b1;
        foreach (step_words[i])
            words_due = {words_due, step_words[i]};
    endtask

    // predictor updates and word checks
    always @(posedge clk)
    begin : monitor
        sws_result_t w;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SEP_LEN)
                    sep_len_reg = cfg_data[3:0];
                else if (cfg_index == CFG_SEP_BYTES)
                    sep_bytes_reg = cfg_data;
                reg_writes++;
            end
            if (in_valid && in_ready)
            begin
                predict_words(text_byte);
                bytes_in++;
            end
            if (out_valid && out_ready)
            begin
                if (words_due.size() == 0)
                    report_mismatch("unexpected word", word_start, 0);
                else
                begin
                    w = words_due.pop_front();
                    if (word_start !== w.word_start)
                        report_mismatch("word_start", word_start, w.word_start);
                    if (word_length !== w.word_length)
                        report_mismatch("word_length", word_length, w.word_length);
                    if (end_kind !== w.end_kind)
                        report_mismatch("end_kind", end_kind, w.end_kind);
                    if (offset_saturated !== w.offset_saturated)
                        report_mismatch("offset_saturated", offset_saturated,
                                        w.offset_saturated);
                    if (last_of_run !== w.last_of_run)
                        report_mismatch("last_of_run", last_of_run, w.last_of_run);
                end
                words_seen++;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
        begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles, %0d words pending",
                         idle_cnt, words_due.size());
                $display("separator_word_splitter_top_tb: errors");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_separator(input int len, input logic [63:0] bytes_v);
        write_reg(CFG_SEP_LEN, 64'(len));
        write_reg(CFG_SEP_BYTES, bytes_v);
    endtask

    task automatic random_separator(input int len);
        logic [63:0] bytes_v;
        int          pick;
        for (int i = 0; i < 8; i++)
        begin
            pick = $urandom_range(19);
            if (pick < 4)
                bytes_v[i*8 +: 8] = 8'h20;
            else if (pick < 6)
                bytes_v[i*8 +: 8] = 8'h2C;
            else if (pick < 8)
                bytes_v[i*8 +: 8] = 8'h2D;
            else if (pick < 11)
                bytes_v[i*8 +: 8] = 8'($urandom_range(97, 99));
            else if (pick == 11)
                bytes_v[i*8 +: 8] = SWS_CHAR_NL;
            else if (pick == 12)
                bytes_v[i*8 +: 8] = 8'hFF;
            else if (pick == 13)
                bytes_v[i*8 +: 8] = SWS_CHAR_NUL;
            else
                bytes_v[i*8 +: 8] = 8'($urandom_range(1, 255));
        end
        set_separator(len, bytes_v);
    endtask

    // mostly words and separators, with newlines, text ends and stray bytes
    task automatic random_stream(input int count);
        int sent;
        int pick;
        int n;
        int k;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            n    = sep_width();
            if (pick < 40)
            begin
                k = $urandom_range(1, 6);
                repeat (k) send_byte(word_char());
                sent += k;
            end
            else if (pick < 72)
            begin
                k = (pick < 62) ? n : $urandom_range(1, n);
                for (int i = 0; i < k; i++)
                    send_byte(sep_char(i));
                sent += k;
            end
            else if (pick < 84)
            begin
                send_byte(SWS_CHAR_NL);
                sent++;
            end
            else if (pick < 91)
            begin
                send_byte(SWS_CHAR_NUL);
                sent++;
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    task automatic test_defaults();
        send_byte(8'hFF);
        send_text("  \n");
        send_byte(SWS_CHAR_NUL);
    endtask

    task automatic test_long_separator();
        set_separator(3, 64'h3E2D3C);
        send_text("<<-<-\n<-");
        send_byte(SWS_CHAR_NUL);
    endtask

    task automatic test_register_extremes();
        set_separator(0, 64'hFFFF_FFFF_FFFF_FF2C);
        send_text("a,");
        send_byte(SWS_CHAR_NUL);
        set_separator(15, '1);
        repeat (8) send_byte(8'hFF);
        send_byte(SWS_CHAR_NUL);
    endtask

    task automatic test_mid_match_change();
        set_separator(4, 64'h64636261);
        send_text("xab");
        write_reg(CFG_SEP_LEN, 64'd2);
        send_text("y");
        send_byte(SWS_CHAR_NUL);
    endtask

    task automatic test_random_traffic();
        src_idle_pct  = 30;
        sink_idle_pct = 63;
        random_separator($urandom_range(1, 3));
        random_stream(135);
        random_separator(SWS_MAX_SEP);
        random_stream(135);
        src_idle_pct  = 63;
        sink_idle_pct = 30;
        random_separator($urandom_range(0, 15));
        random_stream(135);
        random_separator($urandom_range(1, 4));
        random_stream(135);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_separator($urandom_range(2, 5));
        random_stream(135);
        random_separator(1);
        random_stream(135);
    endtask

    task automatic test_backpressure();
        set_separator(1, 64'h3B);
        hold_seq <= hold_seq + 1;
        repeat (30)
        begin
            send_byte(8'h3B);
            send_byte(SWS_CHAR_NL);
        end
        wait_drained();
    endtask

    initial
    begin
        sep_len_reg   = 4'd1;
        sep_bytes_reg = 64'h20;
        in_sep        = 1'b0;
        match_cnt     = '0;
        text_ofs      = '0;
        word_begin    = '0;
        ofs_full      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_long_separator();
        test_register_extremes();
        test_mid_match_change();
        test_random_traffic();
        test_backpressure();

        wait_drained();
        repeat (4) @(posedge clk);
        $display("summary: %0d bytes sent, %0d words checked, %0d register writes, %0d mismatches",
                 bytes_in, words_seen, reg_writes, err_cnt);
        $display("summary: separators of 1 to 8 bytes, out-of-range lengths, mid-match change, "
                 , "output stall with a full queue");
        if (err_cnt == 0 && words_due.size() == 0)
            $display("separator_word_splitter_top_tb: clean");
        else
            $display("separator_word_splitter_top_tb: errors");
        $finish;
    end

endmodule
